### hdl/assert_macros.svh
// Assertion helpers used by the checker file.
// Depends on nothing; expects clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/sld_pkg.sv
// Types, constants and table functions of the segment LCD digit writer.
// Depends on nothing; used by every module of the block.
package sld_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int ROW_COUNT   = 8;
  localparam int ROW_W       = 32;
  localparam int COL_W       = 5;
  localparam int GLYPH_W     = 7;
  localparam int GLYPH_COUNT = 28;
  localparam int NUMBER_W    = 27;
  localparam int STEP_W      = 3;
  localparam int QUEUE_DEPTH = 2;  // power of two, pointers wrap naturally
  localparam int QUEUE_AW    = 1;

  localparam logic [NUMBER_W-1:0] NUMBER_MAX = NUMBER_W'(99999999);
  // q = (v * RECIP10) >> RECIP_SHIFT is exact for any 32-bit v
  localparam logic [31:0] RECIP10     = 32'hCCCCCCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIGIT_COUNT - 1);

  typedef enum logic [2:0] {
    CMD_WRITE     = 3'd0,
    CMD_WRITE_UPD = 3'd1,
    CMD_CLEAR_POS = 3'd2,
    CMD_CLEAR_ALL = 3'd3,
    CMD_FILL_ALL  = 3'd4,
    CMD_SHOW_NUM  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_GLYPH,
    OP_FILL,
    OP_NUMBER
  } op_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_NUMBER
  } back_state_t;

  typedef struct packed {
    logic [2:0]          command;
    logic [7:0]          glyph_code;
    logic [3:0]          digit_position;
    logic [NUMBER_W-1:0] number_value;
  } sld_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] row0_word;
    logic [ROW_W-1:0] row1_word;
    logic [ROW_W-1:0] row2_word;
    logic [ROW_W-1:0] row3_word;
    logic [ROW_W-1:0] row4_word;
    logic [ROW_W-1:0] row5_word;
    logic [ROW_W-1:0] row6_word;
    logic [ROW_W-1:0] row7_word;
    logic             update_request;
  } sld_out_t;

  // Classified command, as it sits in the queue.
  typedef struct packed {
    op_kind_t            kind;
    logic                update;
    logic                pos_ok;
    logic [COL_W-1:0]    column;
    logic [GLYPH_W-1:0]  pattern;
    logic                fill;
    logic [NUMBER_W-1:0] number;
  } sld_op_t;

  typedef logic [ROW_COUNT-1:0][ROW_W-1:0] row_words_t;

  localparam logic [GLYPH_W-1:0] GLYPH_TABLE [GLYPH_COUNT] = '{
    7'h77, 7'h12, 7'h6B, 7'h5B, 7'h1E, 7'h5D, 7'h7D, 7'h13, 7'h7F, 7'h5F,
    7'h3F, 7'h7C, 7'h65, 7'h7A, 7'h6D, 7'h2D, 7'h00, 7'h2F, 7'h37, 7'h64,
    7'h08, 7'h3E, 7'h76, 7'h28, 7'h78, 7'h70, 7'h52, 7'h38
  };

  // Row that takes glyph bit i.
  localparam logic [2:0] BIT_ROW [GLYPH_W] = '{3'd7, 3'd6, 3'd5, 3'd4, 3'd2, 3'd1, 3'd0};

  function automatic logic [GLYPH_W-1:0] glyph_pattern(input logic [7:0] code);
    logic [GLYPH_W-1:0] pat;
    pat = '0;
    if (code < 8'(GLYPH_COUNT)) begin
      pat = GLYPH_TABLE[code[4:0]];
    end
    return pat;
  endfunction

  function automatic logic pos_valid(input logic [3:0] pos);
    return (pos >= 4'd1) && (pos <= 4'(DIGIT_COUNT));
  endfunction

  function automatic logic [COL_W-1:0] pos_column(input logic [3:0] pos);
    logic [COL_W-1:0] col;
    unique case (pos)
      4'd1:    col = 5'd6;
      4'd2:    col = 5'd10;
      4'd3:    col = 5'd11;
      4'd4:    col = 5'd12;
      4'd5:    col = 5'd13;
      4'd6:    col = 5'd14;
      4'd7:    col = 5'd15;
      4'd8:    col = 5'd25;
      default: col = 5'd0;
    endcase
    return col;
  endfunction

  // Replace the seven segment bits of one column.
  function automatic row_words_t put_glyph(input row_words_t rows,
                                           input logic [COL_W-1:0] col,
                                           input logic [GLYPH_W-1:0] pat);
    row_words_t r;
    r = rows;
    for (int i = 0; i < GLYPH_W; i++) begin
      r[BIT_ROW[i]][col] = pat[i];
    end
    return r;
  endfunction

endpackage

### hdl/sld_front.sv
// Front end: takes command beats and classifies them into queue entries.
// Depends on sld_pkg.
module sld_front (
  input  sld_pkg::sld_in_t in_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             q_full,
  output logic             push,
  output sld_pkg::sld_op_t push_data
);
  import sld_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data         = '0;
    push_data.kind    = OP_NOP;
    push_data.pos_ok  = pos_valid(in_data.digit_position);
    push_data.column  = pos_column(in_data.digit_position);
    push_data.pattern = glyph_pattern(in_data.glyph_code);
    push_data.number  = (in_data.number_value > NUMBER_MAX) ? NUMBER_MAX
                                                             : in_data.number_value;
    unique case (cmd_t'(in_data.command))
      CMD_WRITE: begin
        push_data.kind = OP_GLYPH;
      end
      CMD_WRITE_UPD: begin
        push_data.kind   = OP_GLYPH;
        push_data.update = 1'b1;
      end
      CMD_CLEAR_POS: begin
        push_data.kind    = OP_GLYPH;
        push_data.pattern = '0;
      end
      CMD_CLEAR_ALL: begin
        push_data.kind = OP_FILL;
        push_data.fill = 1'b0;
      end
      CMD_FILL_ALL: begin
        push_data.kind = OP_FILL;
        push_data.fill = 1'b1;
      end
      CMD_SHOW_NUM: begin
        push_data.kind   = OP_NUMBER;
        push_data.update = 1'b1;
      end
      default: begin
        push_data.kind = OP_NOP;
      end
    endcase
  end

endmodule

### hdl/sld_queue.sv
// Short FIFO of classified commands between front and back.
// Depends on sld_pkg.
module sld_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sld_pkg::sld_op_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output sld_pkg::sld_op_t q_data
);
  import sld_pkg::*;

  sld_op_t             entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full    = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/sld_back.sv
// Back end: holds the row words, executes queued commands, owns the result register.
// Depends on sld_pkg.
module sld_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  sld_pkg::sld_op_t q_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output sld_pkg::sld_out_t out_data
);
  import sld_pkg::*;

  back_state_t         state;
  back_state_t         state_next;
  row_words_t          rows;
  row_words_t          rows_next;
  logic [NUMBER_W-1:0] num_val;
  logic [STEP_W-1:0]   step;
  logic                out_free;
  logic                out_load;
  logic                out_update;
  logic                start_num;
  logic                adv;

  // digit step: reciprocal multiply for the quotient, remainder by shift-add
  logic [63:0]         prod;
  logic [NUMBER_W-1:0] quot;
  logic [NUMBER_W+2:0] rem_full;
  logic [3:0]          digit;
  logic [3:0]          num_pos;
  logic                num_write;
  row_words_t          num_base;

  assign prod      = {{(32-NUMBER_W){1'b0}}, num_val} * RECIP10;
  assign quot      = prod[RECIP_SHIFT +: NUMBER_W];
  assign rem_full  = {3'b000, num_val} - {quot, 3'b000} - {2'b00, quot, 1'b0};
  assign digit     = rem_full[3:0];
  assign num_pos   = 4'(DIGIT_COUNT) - {1'b0, step};
  // leading zeros suppressed, but the units digit always shows
  assign num_write = (step == '0) || (num_val != '0);
  assign num_base  = (step == '0) ? '0 : rows;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && out_free && (q_data.kind == OP_NUMBER)) begin
          state_next = BK_NUMBER;
        end
      end
      BK_NUMBER: begin
        if ((step == LAST_STEP) && out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    out_load   = 1'b0;
    out_update = 1'b1;
    start_num  = 1'b0;
    adv        = 1'b0;
    rows_next  = rows;
    unique case (state)
      BK_IDLE: begin
        out_update = q_data.update;
        if (q_valid && out_free) begin
          pop = 1'b1;
          unique case (q_data.kind)
            OP_GLYPH: begin
              if (q_data.pos_ok) begin
                rows_next = put_glyph(rows, q_data.column, q_data.pattern);
              end
              out_load = 1'b1;
            end
            OP_FILL: begin
              rows_next = {ROW_COUNT{{ROW_W{q_data.fill}}}};
              out_load  = 1'b1;
            end
            OP_NUMBER: begin
              start_num = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      BK_NUMBER: begin
        if ((step != LAST_STEP) || out_free) begin
          adv       = 1'b1;
          out_load  = (step == LAST_STEP);
          rows_next = num_write ? put_glyph(num_base, pos_column(num_pos),
                                            glyph_pattern({4'd0, digit}))
                                : num_base;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rows      <= '0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      state <= state_next;
      rows  <= rows_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (start_num) begin
        step <= '0;
      end else if (adv) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_num) begin
      num_val <= q_data.number;
    end else if (adv) begin
      num_val <= quot;
    end
    if (out_load) begin
      out_data.row0_word      <= rows_next[0];
      out_data.row1_word      <= rows_next[1];
      out_data.row2_word      <= rows_next[2];
      out_data.row3_word      <= rows_next[3];
      out_data.row4_word      <= rows_next[4];
      out_data.row5_word      <= rows_next[5];
      out_data.row6_word      <= rows_next[6];
      out_data.row7_word      <= rows_next[7];
      out_data.update_request <= out_update;
    end
  end

endmodule

### hdl/segment_lcd_digit_writer.sv
// Segment LCD digit writer, top level: front end, command queue, back end.
// Depends on sld_pkg, sld_front, sld_queue, sld_back.
//
// The block keeps the eight 32-bit row words of a segment LCD (one per
// common line) and edits them one command beat at a time; every command
// returns one result beat with all eight rows as they stand afterwards
// plus the update request flag (set for write-and-update and show number).
// Glyph writes, position clears, clear all, fill all and the unused command
// codes are executed straight from the idle back end, so these run at one
// beat per cycle while out_ready is held high. Show number first loads the
// value, then takes one step per digit position, eight in all, each step a
// multiply by the reciprocal of ten in the back end. Input and output are
// decoupled by a two-entry command queue and a result register, so new
// commands are taken while a result waits for out_ready until the queue
// is full. Reset clears all rows to zero.
module segment_lcd_digit_writer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sld_pkg::sld_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sld_pkg::sld_out_t  out_data
);
  import sld_pkg::*;

  logic    q_full;
  logic    push;
  sld_op_t push_data;
  logic    pop;
  logic    q_valid;
  sld_op_t q_data;

  // decode: command -> op kind, glyph pattern, column, saturated number
  sld_front u_front (
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // lets the front keep taking beats, up to two entries, while a number is being drawn
  sld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // row state, digit loop and result register
  sld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hdl/sld_checker.sv
// Port-level checker for the segment LCD digit writer, bound to the top level.
// Depends on sld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sld_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input sld_pkg::sld_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input sld_pkg::sld_out_t out_data
);
  import sld_pkg::*;

  // beats taken in but not yet returned; queue + digit loop + result reg
  localparam logic [2:0] MAX_PENDING = 3'(QUEUE_DEPTH + 2);

  logic [2:0] pending;
  logic       in_beat;
  logic       out_beat;
  logic       in_stall;
  logic       out_stall;

  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;
  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'b00, in_beat} - {2'b00, out_beat};
    end
  end

  `ASSERT_CLK(a_in_hold, in_stall |=> in_valid && $stable(in_data), "command not held")
  `ASSERT_CLK(a_out_hold, out_stall |=> out_valid && $stable(out_data), "result not held")
  `ASSERT_CLK(a_no_ghost, out_valid |-> pending != 3'd0, "result with no command pending")
  `ASSERT_CLK(a_bounded, pending <= MAX_PENDING, "more commands in flight than storage")
  `ASSERT_ALWAYS(a_rst_ready, rst |=> in_ready && !out_valid, "not empty after reset")

endmodule

bind segment_lcd_digit_writer sld_checker u_sld_checker (.*);
